### rtl/core/sse_pkg.sv
// sse_pkg: shared types and codes for the sorted set engine.
// Operation and status codes, the key type and the cell command bundle.
// No dependencies.
package sse_pkg;

    // Key stored in each cell
    typedef logic signed [31:0] t_value;

    // Operation field of a request
    typedef logic [1:0] t_op;
    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_DELETE = 2'd1;
    localparam t_op OP_TEST   = 2'd2;

    // Status field of a response
    typedef logic [2:0] t_status;
    localparam t_status STS_INSERTED = 3'd0;
    localparam t_status STS_PRESENT  = 3'd1;
    localparam t_status STS_DELETED  = 3'd2;
    localparam t_status STS_MISSING  = 3'd3;
    localparam t_status STS_FOUND    = 3'd4;
    localparam t_status STS_FULL     = 3'd5;

    // Width of the entry count field of a response
    localparam int COUNT_W = 7;
    typedef logic [COUNT_W-1:0] t_count_field;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic cmp;  // register compare flags against the key
        logic ins;  // open a slot at the insert point, shift up
        logic del;  // close the slot at the match point, shift down
    } t_cell_cmd;

endpackage

### rtl/core/sse_req_if.sv
// sse_req_if: request channel of the sorted set engine (valid/ready).
// Depends on sse_pkg.
interface sse_req_if;
    import sse_pkg::*;

    logic   valid;
    logic   ready;
    t_op    operation;
    t_value value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

### rtl/core/sse_rsp_if.sv
// sse_rsp_if: response channel of the sorted set engine (valid/ready).
// Depends on sse_pkg.
interface sse_rsp_if;
    import sse_pkg::*;

    logic         valid;
    logic         ready;
    t_status      status;
    t_count_field entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

### rtl/core/sse_cell.sv
// sse_cell: one slot of the sorted chain. Holds a key, compares it with the
// broadcast key and shifts toward either neighbor on insert or delete.
// Depends on sse_pkg.
module sse_cell (
    input  logic               i_clk,
    input  sse_pkg::t_cell_cmd i_cmd,
    input  sse_pkg::t_value    i_key,
    input  logic               i_occ,
    input  sse_pkg::t_value    i_left_val,
    input  logic               i_left_lt,
    input  sse_pkg::t_value    i_right_val,
    output sse_pkg::t_value    o_val,
    output logic               o_lt,
    output logic               o_eq
);
    import sse_pkg::*;

    t_value r_val;
    t_value n_val;
    logic   r_lt;
    logic   r_eq;

    // Compare flags, only meaningful for occupied slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_lt <= i_occ && (r_val < i_key);
            r_eq <= i_occ && (r_val == i_key);
        end
    end

    // Slots at or above the insert/match point move; those below stay
    always_comb begin
        n_val = r_val;
        if (i_cmd.ins && !r_lt) begin
            n_val = i_left_lt ? i_key : i_left_val;
        end else if (i_cmd.del && !r_lt) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

### rtl/core/sorted_set_engine.sv
// sorted_set_engine: top level; controller, output register and the cell chain.
// Depends on sse_pkg, sse_req_if, sse_rsp_if and sse_cell.
//
// Keeps up to CAPACITY distinct signed 32-bit keys in ascending order, one key
// per cell of a chain. Each request inserts, deletes or looks up one key and
// yields exactly one response carrying the outcome and the entry count after
// the operation (low 7 bits). A request passes through the accept cycle,
// a compare cycle in which every cell registers its less-than and equal flags
// against the key, and an update cycle in which the cells shift one place
// toward or away from the insert point while the response is loaded. One
// request is in flight at a time; a new request is taken only after the update
// cycle of the current one has ended. The response sits in an output register,
// so a new request is taken while it waits; the update cycle holds only if the
// previous response has not yet been taken.
// Reset empties the set; cell contents need no clearing.
module sorted_set_engine #(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sse_req_if.sink   i_req,
    sse_rsp_if.source o_rsp
);
    import sse_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    t_op           r_op;
    t_value        r_key;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic          r_out_valid;
    t_status       r_out_status;
    t_count_field  r_out_count;
    t_status       n_status;
    logic [CW+COUNT_W-1:0] w_count_wide;

    t_cell_cmd     w_cmd;
    t_value        w_val [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic          w_present;
    logic          w_full;
    logic          w_out_free;
    logic          w_done;

    // Request handshake: take a new transaction only when idle
    assign i_req.ready = (r_state == S_IDLE);

    assign w_present  = |w_eq;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_done     = (r_state == S_UPD) && w_out_free;

    // Outcome and cell commands: compare in the compare cycle, shift in the update cycle
    always_comb begin
        w_cmd     = '0;
        w_cmd.cmp = (r_state == S_CMP);
        n_count   = r_count;
        case (r_op)
            OP_INSERT: begin
                if (w_present) begin
                    n_status = STS_PRESENT;
                end else if (w_full) begin
                    n_status = STS_FULL;
                end else begin
                    n_status  = STS_INSERTED;
                    w_cmd.ins = w_done;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_DELETE: begin
                if (w_present) begin
                    n_status  = STS_DELETED;
                    w_cmd.del = w_done;
                    n_count   = r_count - CW'(1);
                end else begin
                    n_status = STS_MISSING;
                end
            end
            default: begin
                n_status = w_present ? STS_FOUND : STS_MISSING;
            end
        endcase
    end

    assign w_count_wide = (CW + COUNT_W)'(n_count);

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_req.valid) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_count <= n_count;
            end
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op  <= i_req.operation;
            r_key <= i_req.value;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_status <= n_status;
            r_out_count  <= w_count_wide[COUNT_W-1:0];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_count;

    // Cell chain: left neighbor feeds inserts, right neighbor feeds deletes
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_value w_left_val;
        logic   w_left_lt;
        t_value w_right_val;

        if (g == 0) begin : g_head
            assign w_left_val = r_key;
            assign w_left_lt  = 1'b1;
        end else begin : g_body
            assign w_left_val = w_val[g-1];
            assign w_left_lt  = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_val = w_val[g];
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
        end

        sse_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_key       (r_key),
            .i_occ       (CW'(g) < r_count),
            .i_left_val  (w_left_val),
            .i_left_lt   (w_left_lt),
            .i_right_val (w_right_val),
            .o_val       (w_val[g]),
            .o_lt        (w_lt[g]),
            .o_eq        (w_eq[g])
        );
    end

endmodule

### tb/sv/sorted_set_engine_test.sv
// sorted_set_engine_test: self-checking testbench for the sorted set engine.
// Drives insert, delete and lookup requests and checks each response against
// a queue-based set predictor. Depends on sse_pkg, sse_req_if, sse_rsp_if and the RTL top.
`timescale 1ns / 1ps

module sorted_set_engine_test;
    import sse_pkg::*;

    // Unused operation code; the block treats it as a lookup
    localparam t_op OP_SPARE = 2'd3;

    localparam int SET_CAPACITY  = 64;
    localparam int KEY_POOL_SIZE = 72;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct {
        t_op    op;
        t_value value;
    } t_set_cmd;

    typedef struct {
        t_status      status;
        t_count_field count;
    } t_set_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sse_req_if req_ch ();
    sse_rsp_if rsp_ch ();

    sorted_set_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state and scoreboard
    t_value       held_keys[$];
    t_set_cmd     pending_cmds[$];
    t_set_outcome expected_outcomes[$];
    int           error_count;
    int           requests_sent;
    int           responses_seen;
    int           peak_held;
    int           status_tally[6];
    int           cycle_count;
    int           hold_left;
    int           holds_done;

    // Random idle gaps, with quiet stretches where both sides run flat out
    function automatic int idle_draw();
        if ((cycle_count % 2000) < 400)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Apply one request to the predicted set and return the expected response
    function automatic t_set_outcome apply_set_op(t_set_cmd cmd);
        int           pos;
        bit           hit;
        t_set_outcome res;
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < cmd.value)
            pos++;
        hit = (pos < held_keys.size()) && (held_keys[pos] == cmd.value);
        case (cmd.op)
            OP_INSERT: begin
                if (hit) begin
                    res.status = STS_PRESENT;
                end else if (held_keys.size() >= SET_CAPACITY) begin
                    res.status = STS_FULL;
                end else begin
                    held_keys.insert(pos, cmd.value);
                    res.status = STS_INSERTED;
                end
            end
            OP_DELETE: begin
                if (hit) begin
                    held_keys.delete(pos);
                    res.status = STS_DELETED;
                end else begin
                    res.status = STS_MISSING;
                end
            end
            default: begin
                res.status = hit ? STS_FOUND : STS_MISSING;
            end
        endcase
        res.count = t_count_field'(held_keys.size());
        if (held_keys.size() > peak_held)
            peak_held = held_keys.size();
        status_tally[res.status]++;
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    task automatic push_cmd(t_op op, t_value value);
        t_set_cmd cmd;
        cmd.op    = op;
        cmd.value = value;
        pending_cmds.push_back(cmd);
    endtask

    // Request driver: one transaction per accepted handshake
    t_set_cmd on_wire;
    int       send_wait;
    always @(posedge i_clk) begin
        bit accepted;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_wait = 0;
        end else begin
            accepted = req_ch.valid && req_ch.ready;
            if (accepted) begin
                expected_outcomes.push_back(apply_set_op(on_wire));
                requests_sent++;
                send_wait = idle_draw();
            end
            if (accepted || !req_ch.valid) begin
                // Count down the idle gap before offering the next transaction
                if (!accepted && send_wait > 0)
                    send_wait--;
                if (send_wait == 0 && pending_cmds.size() > 0) begin
                    on_wire = pending_cmds.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.operation <= on_wire.op;
                    req_ch.value     <= on_wire.value;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off so the engine backs up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && requests_sent >= 400) ||
                     (holds_done == 1 && requests_sent >= 900)) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Response monitor: compare each transaction with the oldest expectation
    int recv_wait;
    always @(posedge i_clk) begin
        t_set_outcome want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                responses_seen++;
                if (expected_outcomes.size() == 0) begin
                    report_mismatch($sformatf("response with nothing outstanding (status %0d)",
                                              rsp_ch.status));
                end else begin
                    want = expected_outcomes.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("response %0d status %0d, want %0d",
                                                  responses_seen, rsp_ch.status, want.status));
                    if (rsp_ch.entry_count !== want.count)
                        report_mismatch($sformatf("response %0d count %0d, want %0d",
                                                  responses_seen, rsp_ch.entry_count,
                                                  want.count));
                end
                recv_wait = idle_draw();
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            rsp_ch.ready <= (recv_wait == 0) && (hold_left == 0);
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, expected_outcomes.size());
        $display("simulation failed");
        $finish;
    end

    // Stimulus, reset and end of run
    initial begin
        t_value key_pool[KEY_POOL_SIZE];
        int     pick;
        int     roll;
        error_count    = 0;
        requests_sent  = 0;
        responses_seen = 0;
        peak_held      = 0;
        foreach (status_tally[s])
            status_tally[s] = 0;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_INSERT;
        req_ch.value     = '0;
        rsp_ch.ready     = 1'b0;

        // Directed: empty store, key extremes, head/middle/tail deletes, spare code
        push_cmd(OP_TEST,   32'sd5);
        push_cmd(OP_DELETE, 32'sd5);
        push_cmd(OP_SPARE,  32'sd5);
        push_cmd(OP_INSERT, 32'sd0);
        push_cmd(OP_INSERT, 32'sh8000_0000);
        push_cmd(OP_INSERT, 32'sh7FFF_FFFF);
        push_cmd(OP_INSERT, -32'sd1);
        push_cmd(OP_INSERT, 32'sd1);
        push_cmd(OP_INSERT, 32'sd0);
        push_cmd(OP_TEST,   32'sh8000_0000);
        push_cmd(OP_TEST,   32'sh7FFF_FFFF);
        push_cmd(OP_SPARE,  32'sh7FFF_FFFF);
        push_cmd(OP_TEST,   32'sd2);
        push_cmd(OP_INSERT, 32'sh5555_5555);
        push_cmd(OP_INSERT, 32'shAAAA_AAAA);
        push_cmd(OP_DELETE, 32'sh8000_0000);
        push_cmd(OP_DELETE, 32'sh7FFF_FFFF);
        push_cmd(OP_DELETE, 32'sd0);
        push_cmd(OP_DELETE, 32'sd0);
        push_cmd(OP_TEST,   -32'sd1);
        push_cmd(OP_DELETE, -32'sd1);
        push_cmd(OP_DELETE, 32'sd1);
        push_cmd(OP_DELETE, 32'sh5555_5555);
        push_cmd(OP_DELETE, 32'shAAAA_AAAA);

        // Random rounds: aim to fill past capacity, churn, then mostly drain
        for (int round = 0; round < 4; round++) begin
            foreach (key_pool[k]) begin
                roll = $urandom_range(0, 9);
                if (roll < 4)
                    key_pool[k] = t_value'($urandom);
                else if (roll == 4)
                    key_pool[k] = (k % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                else
                    key_pool[k] = t_value'($urandom_range(0, 96)) - 32'sd48;
            end
            for (int k = 0; k < 110; k++) begin
                roll = $urandom_range(0, 99);
                pick = $urandom_range(0, KEY_POOL_SIZE - 1);
                if (roll < 80)
                    push_cmd(OP_INSERT, key_pool[k % KEY_POOL_SIZE]);
                else if (roll < 88)
                    push_cmd(OP_TEST, key_pool[pick]);
                else if (roll < 93)
                    push_cmd(OP_SPARE, key_pool[pick]);
                else if (roll < 96)
                    push_cmd(OP_DELETE, key_pool[pick]);
                else
                    push_cmd(OP_INSERT, t_value'($urandom));
            end
            for (int k = 0; k < 90; k++) begin
                pick = $urandom_range(0, KEY_POOL_SIZE - 1);
                push_cmd(t_op'($urandom_range(0, 3)),
                         ($urandom_range(0, 9) == 0) ? t_value'($urandom) : key_pool[pick]);
            end
            for (int k = 0; k < 80; k++) begin
                roll = $urandom_range(0, 99);
                pick = $urandom_range(0, KEY_POOL_SIZE - 1);
                if (roll < 85)
                    push_cmd(OP_DELETE, key_pool[k % KEY_POOL_SIZE]);
                else if (roll < 95)
                    push_cmd(OP_TEST, key_pool[pick]);
                else
                    push_cmd(OP_INSERT, key_pool[pick]);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || req_ch.valid)
            @(posedge i_clk);
        while (expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests, %0d responses, peak occupancy %0d of %0d",
                 requests_sent, responses_seen, peak_held, SET_CAPACITY);
        $display("inserted %0d, present %0d, deleted %0d, missing %0d, found %0d, full %0d",
                 status_tally[STS_INSERTED], status_tally[STS_PRESENT],
                 status_tally[STS_DELETED], status_tally[STS_MISSING],
                 status_tally[STS_FOUND], status_tally[STS_FULL]);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
